// File: hw/rtl/cst_pkg.sv
// Shared types, constants and arithmetic helpers of the cardinal spline tessellator.
package cst_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_STEPS  = 32;
  localparam int GAIN_W     = 17;
  localparam int STEPS_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_W      = 16;

  localparam int TAN_W   = COORD_BITS + 18;
  localparam int COEF_W  = COORD_BITS + 22;
  localparam int NUM_W   = COORD_BITS + 38;
  localparam int QBITS   = COORD_BITS + 2;
  localparam int REM_W   = QBITS + 16;
  localparam int SQ_W    = 11;
  localparam int CUBE_W  = 16;
  localparam int K_W     = $clog2(MAX_STEPS);
  localparam int QI_W    = $clog2(QBITS);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [GAIN_W-1:0]    GAIN_ONE      = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]    TENSION_RESET = GAIN_W'(32768);
  localparam logic [STEPS_W-1:0]   STEPS_RESET   = STEPS_W'(32);
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COORD_BITS-1:0]   p1x;
    logic [COORD_BITS-1:0]   p1y;
    logic [COORD_BITS-1:0]   p2x;
    logic [COORD_BITS-1:0]   p2y;
    logic signed [TAN_W-1:0] v1x;
    logic signed [TAN_W-1:0] v1y;
    logic signed [TAN_W-1:0] v2x;
    logic signed [TAN_W-1:0] v2y;
    logic                    last;
  } seg_cmd_t;

  // gain * (a - b), pixels with 16 fraction bits
  function automatic logic signed [TAN_W-1:0] tangent(input logic [GAIN_W-1:0] g,
                                                     input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic signed [TAN_W:0]      prod;
    d    = $signed({1'b0, a}) - $signed({1'b0, b});
    prod = $signed({1'b0, g}) * d;
    return prod[TAN_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] pos_scaled(input logic [COORD_BITS-1:0] p);
    return $signed(COEF_W'({p, 16'h0000}));
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_a(input logic [COORD_BITS-1:0] p1,
                                                     input logic [COORD_BITS-1:0] p2,
                                                     input logic signed [TAN_W-1:0] v1,
                                                     input logic signed [TAN_W-1:0] v2);
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    a1 = pos_scaled(p1);
    a2 = pos_scaled(p2);
    return (a1 <<< 1) - (a2 <<< 1) + COEF_W'(v1) + COEF_W'(v2);
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_b(input logic [COORD_BITS-1:0] p1,
                                                     input logic [COORD_BITS-1:0] p2,
                                                     input logic signed [TAN_W-1:0] v1,
                                                     input logic signed [TAN_W-1:0] v2);
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] w1;
    b1 = pos_scaled(p1);
    b2 = pos_scaled(p2);
    w1 = COEF_W'(v1);
    return (b2 <<< 1) + b2 - (b1 <<< 1) - b1 - (w1 <<< 1) - COEF_W'(v2);
  endfunction

  function automatic logic [STEPS_W-1:0] clamp_steps(input logic [STEPS_W-1:0] s);
    logic [STEPS_W-1:0] r;
    r = s;
    if (s == '0) r = STEPS_W'(1);
    else if (s > STEPS_W'(MAX_STEPS)) r = STEPS_W'(MAX_STEPS);
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [QBITS:0] v);
    logic signed [QBITS+OUT_W:0] w;
    logic signed [OUT_W-1:0]     r;
    w = v;
    if (w > 32767) r = 16'sh7FFF;
    else if (w < -32768) r = -16'sh8000;
    else r = w[OUT_W-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/cst_cmdq.sv
// Short segment command queue between the point front end and the sample engine.
module cst_cmdq (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_push,
  input  cst_pkg::seg_cmd_t  wr_data,
  output logic               wr_full,
  input  logic               rd_pop,
  output cst_pkg::seg_cmd_t  rd_data,
  output logic               rd_empty
);

  cst_pkg::seg_cmd_t              entries [cst_pkg::CMDQ_DEPTH];
  logic [cst_pkg::CMDQ_AW-1:0]    wr_ptr;
  logic [cst_pkg::CMDQ_AW-1:0]    rd_ptr;
  logic [cst_pkg::CMDQ_AW:0]      count;

  assign wr_full  = (count == (cst_pkg::CMDQ_AW+1)'(cst_pkg::CMDQ_DEPTH));
  assign rd_empty = (count == '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_push) begin
      entries[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_push) wr_ptr <= wr_ptr + 1'b1;
      if (rd_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr_push, rd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    wr_push |-> (count < (cst_pkg::CMDQ_AW+1)'(cst_pkg::CMDQ_DEPTH)))
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    rd_pop |-> (count != '0))
    else $error("command queue read while empty");

endmodule

// File: hw/rtl/cst_front.sv
// Point front end: keeps the last points and tangent, turns points into segment commands.
module cst_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [cst_pkg::COORD_BITS-1:0]    point_x,
  input  logic [cst_pkg::COORD_BITS-1:0]    point_y,
  input  logic                              final_point,
  input  logic [cst_pkg::GAIN_W-1:0]        gain,
  output logic                              q_push,
  output cst_pkg::seg_cmd_t                 q_data,
  input  logic                              q_full
);

  logic [1:0]                           points_seen;
  logic [cst_pkg::COORD_BITS-1:0]       older_x, older_y, newer_x, newer_y;
  logic signed [cst_pkg::TAN_W-1:0]     otan_x, otan_y;
  cst_pkg::seg_cmd_t                    pend;
  logic                                 pend_valid;

  logic                                 accept;
  logic signed [cst_pkg::TAN_W-1:0]     t1_x, t1_y, tn_x, tn_y, tl_x, tl_y;
  cst_pkg::seg_cmd_t                    seg_now;
  logic                                 seg_emit;

  assign full   = pend_valid || q_full;
  assign accept = push && !full;

  // first-difference tangent (two-point curves), central and closing tangents
  assign t1_x = cst_pkg::tangent(gain, point_x, newer_x);
  assign t1_y = cst_pkg::tangent(gain, point_y, newer_y);
  assign tn_x = cst_pkg::tangent(gain, point_x, older_x);
  assign tn_y = cst_pkg::tangent(gain, point_y, older_y);
  assign tl_x = t1_x;
  assign tl_y = t1_y;

  always_comb begin
    seg_now  = '0;
    seg_emit = 1'b0;
    unique case (points_seen)
      2'd1: begin
        seg_now  = '{p1x: newer_x, p1y: newer_y, p2x: point_x, p2y: point_y,
                     v1x: t1_x, v1y: t1_y, v2x: t1_x, v2y: t1_y, last: 1'b1};
        seg_emit = final_point;
      end
      2'd2: begin
        seg_now  = '{p1x: older_x, p1y: older_y, p2x: newer_x, p2y: newer_y,
                     v1x: otan_x, v1y: otan_y, v2x: tn_x, v2y: tn_y,
                     last: !final_point};
        seg_emit = 1'b1;
      end
      default: begin
        seg_emit = 1'b0;
      end
    endcase
  end

  assign q_push = pend_valid ? !q_full : (accept && seg_emit);
  assign q_data = pend_valid ? pend : seg_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
      pend_valid  <= 1'b0;
      older_x     <= '0;
      older_y     <= '0;
      newer_x     <= '0;
      newer_y     <= '0;
      otan_x      <= '0;
      otan_y      <= '0;
    end else begin
      if (pend_valid && !q_full) pend_valid <= 1'b0;
      if (accept) begin
        unique case (points_seen)
          2'd0: begin
            if (!final_point) begin
              newer_x     <= point_x;
              newer_y     <= point_y;
              points_seen <= 2'd1;
            end
          end
          2'd1: begin
            if (final_point) begin
              points_seen <= 2'd0;
            end else begin
              otan_x      <= t1_x;
              otan_y      <= t1_y;
              older_x     <= newer_x;
              older_y     <= newer_y;
              newer_x     <= point_x;
              newer_y     <= point_y;
              points_seen <= 2'd2;
            end
          end
          default: begin
            if (final_point) begin
              // hold the closing segment until the queue takes it
              pend        <= '{p1x: newer_x, p1y: newer_y, p2x: point_x, p2y: point_y,
                               v1x: tn_x, v1y: tn_y, v2x: tl_x, v2y: tl_y, last: 1'b1};
              pend_valid  <= 1'b1;
              points_seen <= 2'd0;
            end else begin
              older_x <= newer_x;
              older_y <= newer_y;
              otan_x  <= tn_x;
              otan_y  <= tn_y;
              newer_x <= point_x;
              newer_y <= point_y;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/cst_back.sv
// Sample engine: evaluates Hermite samples of queued segments and rounds them.
module cst_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cst_pkg::STEPS_W-1:0]       steps,
  input  logic                              q_empty,
  input  cst_pkg::seg_cmd_t                 q_data,
  output logic                              q_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [cst_pkg::OUT_W-1:0]  curve_x,
  output logic signed [cst_pkg::OUT_W-1:0]  curve_y,
  output logic                              run_end
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_SCALE, ST_H0, ST_H1, ST_H2, ST_ROUND, ST_DIV, ST_OUT
  } state_t;

  state_t                                state;
  cst_pkg::seg_cmd_t                     cmd;
  logic [cst_pkg::STEPS_W-1:0]           s;
  logic [cst_pkg::SQ_W-1:0]              s2;
  logic [cst_pkg::CUBE_W-1:0]            s3;
  logic [cst_pkg::K_W-1:0]               k;
  logic signed [cst_pkg::COEF_W-1:0]     a_x, a_y, b_x, b_y;
  logic [cst_pkg::NUM_W-1:0]             p1s3_x, p1s3_y;
  logic signed [cst_pkg::NUM_W-1:0]      acc_x, acc_y;
  logic [cst_pkg::REM_W-1:0]             rem_x, rem_y, dsh;
  logic [cst_pkg::QBITS-1:0]             q_x, q_y;
  logic [cst_pkg::QI_W-1:0]              qi;
  logic                                  out_valid;

  logic [cst_pkg::STEPS_W-1:0]           s_clamped;
  logic signed [cst_pkg::K_W:0]          k_s;
  logic signed [cst_pkg::STEPS_W:0]      s_s;
  logic signed [cst_pkg::SQ_W:0]         s2_s;
  logic [cst_pkg::NUM_W-1:0]             offset;
  logic signed [cst_pkg::NUM_W-1:0]      nsum_x, nsum_y;
  logic                                  ge_x, ge_y;
  logic                                  k_last;
  logic                                  out_free;
  logic signed [cst_pkg::QBITS:0]        res_x, res_y;

  assign s_clamped = cst_pkg::clamp_steps(steps);
  assign k_s       = $signed({1'b0, k});
  assign s_s       = $signed({1'b0, s});
  assign s2_s      = $signed({1'b0, s2});
  // half a unit for rounding plus a bias that keeps the dividend positive
  assign offset    = (cst_pkg::NUM_W'(s3) << 15) + (cst_pkg::NUM_W'(s3) << (15 + cst_pkg::QBITS));
  assign nsum_x    = acc_x + $signed(offset);
  assign nsum_y    = acc_y + $signed(offset);
  assign ge_x      = (rem_x >= dsh);
  assign ge_y      = (rem_y >= dsh);
  assign k_last    = (cst_pkg::STEPS_W'(k) == s - cst_pkg::STEPS_W'(1));
  assign out_free  = !out_valid || pop;
  assign res_x     = $signed({1'b0, q_x}) - $signed({2'b01, {(cst_pkg::QBITS-1){1'b0}}});
  assign res_y     = $signed({1'b0, q_y}) - $signed({2'b01, {(cst_pkg::QBITS-1){1'b0}}});

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      s         <= cst_pkg::STEPS_W'(1);
      qi        <= '0;
    end else begin
      // load a new sample or drop the one just read
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_data;
            s     <= s_clamped;
            s2    <= cst_pkg::SQ_W'(s_clamped * s_clamped);
            k     <= '0;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          s3    <= cst_pkg::CUBE_W'(s2 * s);
          a_x   <= cst_pkg::coef_a(cmd.p1x, cmd.p2x, cmd.v1x, cmd.v2x);
          a_y   <= cst_pkg::coef_a(cmd.p1y, cmd.p2y, cmd.v1y, cmd.v2y);
          b_x   <= cst_pkg::coef_b(cmd.p1x, cmd.p2x, cmd.v1x, cmd.v2x);
          b_y   <= cst_pkg::coef_b(cmd.p1y, cmd.p2y, cmd.v1y, cmd.v2y);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          p1s3_x <= cst_pkg::NUM_W'({cmd.p1x, 16'h0000}) * cst_pkg::NUM_W'(s3);
          p1s3_y <= cst_pkg::NUM_W'({cmd.p1y, 16'h0000}) * cst_pkg::NUM_W'(s3);
          state  <= ST_H0;
        end
        // Horner form: ((A k + B s) k + V1 s^2) k + P1 s^3
        ST_H0: begin
          acc_x <= a_x * k_s + b_x * s_s;
          acc_y <= a_y * k_s + b_y * s_s;
          state <= ST_H1;
        end
        ST_H1: begin
          acc_x <= acc_x * k_s + cmd.v1x * s2_s;
          acc_y <= acc_y * k_s + cmd.v1y * s2_s;
          state <= ST_H2;
        end
        ST_H2: begin
          acc_x <= acc_x * k_s + $signed(p1s3_x);
          acc_y <= acc_y * k_s + $signed(p1s3_y);
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rem_x <= nsum_x[cst_pkg::REM_W+15:16];
          rem_y <= nsum_y[cst_pkg::REM_W+15:16];
          dsh   <= cst_pkg::REM_W'(s3) << (cst_pkg::QBITS - 1);
          qi    <= cst_pkg::QI_W'(cst_pkg::QBITS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (ge_x) rem_x <= rem_x - dsh;
          if (ge_y) rem_y <= rem_y - dsh;
          q_x <= {q_x[cst_pkg::QBITS-2:0], ge_x};
          q_y <= {q_y[cst_pkg::QBITS-2:0], ge_y};
          dsh <= dsh >> 1;
          qi  <= qi - 1'b1;
          if (qi == '0) state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            curve_x   <= cst_pkg::sat16(res_x);
            curve_y   <= cst_pkg::sat16(res_y);
            run_end   <= cmd.last && k_last;
            if (k_last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_H0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (cst_pkg::STEPS_W'(k) < s))
    else $error("sample index beyond step count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !pop) |=> (state == ST_OUT))
    else $error("sample engine advanced over an unread result");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem_x} < {dsh, 1'b0}) && ({1'b0, rem_y} < {dsh, 1'b0}))
    else $error("divider remainder out of range");

endmodule

// File: hw/rtl/cardinal_spline_tessellator_unit.sv
// Top level of the cardinal spline tessellator: configuration registers and block wiring.
//
// Control points enter through a queue-like port: an item is taken at a clock edge
// with push high and full low. Samples leave the same way: while empty is low the
// oldest sample sits on curve_x, curve_y and run_end, and pop takes it.
// run_end marks the last sample caused by one control point.
// Configuration: cfg_index 0 is tension (Q1.16), 1 is steps per segment; ready is
// always high, other indexes are dropped. Write only while the block is idle.
// A point that closes a segment queues one command (two for the final point of a
// curve with three or more points). For each segment the sample engine takes the
// command and forms the coefficients and P1 times steps cubed, then for each
// sample runs three Horner steps, a rounding step, COORD_BITS + 2 quotient bits of
// the divider by steps cubed and an output load. Input stalls when the 4-entry
// command queue fills, and after the final point of a curve of three or more
// points while its closing segment waits for the queue. If the receiver holds pop
// low, the engine waits on the output register and the queue then backs up into
// full.
// Reset (synchronous) clears the curve, the command queue and the output register and
// loads tension 32768 and 32 steps.
module cardinal_spline_tessellator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [cst_pkg::COORD_BITS-1:0]      point_x,
  input  logic [cst_pkg::COORD_BITS-1:0]      point_y,
  input  logic                                final_point,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [cst_pkg::OUT_W-1:0]    curve_x,
  output logic signed [cst_pkg::OUT_W-1:0]    curve_y,
  output logic                                run_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cst_pkg::GAIN_W-1:0]          cfg_data
);

  logic [cst_pkg::GAIN_W-1:0]   tension;
  logic [cst_pkg::STEPS_W-1:0]  steps_per_segment;
  logic [cst_pkg::GAIN_W-1:0]   gain;

  logic                         cq_push, cq_full, cq_pop, cq_empty;
  cst_pkg::seg_cmd_t            cq_wr, cq_rd;

  assign cfg_ready = 1'b1;
  assign gain = (tension > cst_pkg::GAIN_ONE) ? cst_pkg::GAIN_ONE : tension;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension           <= cst_pkg::TENSION_RESET;
      steps_per_segment <= cst_pkg::STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cst_pkg::CFG_TENSION) tension <= cfg_data;
      else if (cfg_index == cst_pkg::CFG_STEPS)
        steps_per_segment <= cfg_data[cst_pkg::STEPS_W-1:0];
    end
  end

  cst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .point_x     (point_x),
    .point_y     (point_y),
    .final_point (final_point),
    .gain        (gain),
    .q_push      (cq_push),
    .q_data      (cq_wr),
    .q_full      (cq_full)
  );

  cst_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_push  (cq_push),
    .wr_data  (cq_wr),
    .wr_full  (cq_full),
    .rd_pop   (cq_pop),
    .rd_data  (cq_rd),
    .rd_empty (cq_empty)
  );

  cst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .steps   (steps_per_segment),
    .q_empty (cq_empty),
    .q_data  (cq_rd),
    .q_pop   (cq_pop),
    .pop     (pop),
    .empty   (empty),
    .curve_x (curve_x),
    .curve_y (curve_y),
    .run_end (run_end)
  );

endmodule
